FILE: hdl/bale_pkg.sv
// Shared types, codes and sizes for the bounded array list engine.
`default_nettype none

package bale_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_TAIL = 3'd3,
        OP_DEL_HEAD = 3'd4,
        OP_DEL_VAL  = 3'd5,
        OP_DEL_POS  = 3'd6,
        OP_CLEAR    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         position;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        AT_HOLD,
        AT_ZERO,
        AT_COUNT,
        AT_POS
    } at_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_VAL
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        logic    load_req;
        at_sel_t at_sel;
        idx_op_t idx_op;
        wr_op_t  wr_op;
        cnt_op_t cnt_op;
        logic    st_load;
        status_t st_code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_bad;
        logic idx_above_at;
        logic idx_next_held;
        logic idx_end;
        logic match;
    } flags_t;

endpackage

`default_nettype wire

FILE: hdl/bale_dp.sv
// Datapath: entry storage, count, walk index and result register.
`default_nettype none

module bale_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bale_pkg::req_t  req,
    input  wire bale_pkg::cmd_t  cmd,
    output bale_pkg::flags_t     flags,
    output bale_pkg::rsp_t       rsp
);
    import bale_pkg::*;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   val_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] at_reg;
    logic [CW-1:0] at_next;
    status_t       status_reg;
    rsp_t          rsp_reg;
    logic [CW-1:0] req_pos;
    logic [CW-1:0] idx_plus;
    logic [CW-1:0] idx_minus;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic [31:0]   wr_data;

    assign req_pos   = CW'(req.position);
    assign idx_plus  = idx_reg + CW'(1);
    assign idx_minus = idx_reg - CW'(1);

    // Shift read port; its address follows the direction of the current shift.
    always_comb
    begin
        case (cmd.wr_op)
            WR_UP:   rd_addr = idx_minus[AW-1:0];
            WR_DOWN: rd_addr = idx_plus[AW-1:0];
            default: rd_addr = idx_reg[AW-1:0];
        endcase
    end

    assign rd_data = mem[rd_addr];
    assign wr_data = (cmd.wr_op == WR_VAL) ? val_reg : rd_data;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_op != WR_NONE)
        begin
            mem[idx_reg[AW-1:0]] <= wr_data;
        end
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
        case (cmd.idx_op)
            IDX_ZERO:  idx_next = '0;
            IDX_COUNT: idx_next = count_reg;
            IDX_POS:   idx_next = req_pos;
            IDX_INC:   idx_next = idx_plus;
            IDX_DEC:   idx_next = idx_minus;
            default:   idx_next = idx_reg;
        endcase
        case (cmd.at_sel)
            AT_ZERO:  at_next = '0;
            AT_COUNT: at_next = count_reg;
            AT_POS:   at_next = req_pos;
            default:  at_next = at_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        at_reg  <= at_next;
        if (cmd.load_req)
        begin
            val_reg <= req.item_value;
        end
        if (cmd.st_load)
        begin
            status_reg <= cmd.st_code;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.count  <= 5'(count_reg);
        end
    end

    assign flags.full          = (count_reg >= CW'(CAPACITY));
    assign flags.empty         = (count_reg == '0);
    assign flags.pos_bad       = (req_pos >= count_reg);
    assign flags.idx_above_at  = (idx_reg > at_reg);
    assign flags.idx_next_held = (idx_plus < count_reg);
    assign flags.idx_end       = (idx_reg == count_reg);
    assign flags.match         = (mem[idx_reg[AW-1:0]] == val_reg);

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: hdl/bale_ctrl.sv
// Controller: decodes a request and sequences the shift and search walks.
`default_nettype none

module bale_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic [2:0]       req_type,
    output logic                  req_stall,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    input  wire bale_pkg::flags_t flags,
    output bale_pkg::cmd_t        cmd
);
    import bale_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    op_t    op;

    assign op        = op_t'(req_type);
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.st_code = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.st_load  = 1'b1;
                    state_next   = S_FINISH;
                    case (op)
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
                        begin
                            if (flags.full)
                            begin
                                cmd.st_code = ST_FULL;
                            end
                            else if (op == OP_INS_POS && flags.pos_bad)
                            begin
                                cmd.st_code = ST_BADPOS;
                            end
                            else
                            begin
                                cmd.idx_op = IDX_COUNT;
                                if (op == OP_INS_HEAD)
                                begin
                                    cmd.at_sel = AT_ZERO;
                                end
                                else if (op == OP_INS_TAIL)
                                begin
                                    cmd.at_sel = AT_COUNT;
                                end
                                else
                                begin
                                    cmd.at_sel = AT_POS;
                                end
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_DEL_TAIL:
                        begin
                            if (flags.empty)
                            begin
                                cmd.st_code = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.cnt_op = CNT_DEC;
                            end
                        end
                        OP_DEL_HEAD:
                        begin
                            if (flags.empty)
                            begin
                                cmd.st_code = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.idx_op = IDX_ZERO;
                                state_next = S_SHIFT_DOWN;
                            end
                        end
                        OP_DEL_VAL:
                        begin
                            if (flags.empty)
                            begin
                                cmd.st_code = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.idx_op = IDX_ZERO;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_DEL_POS:
                        begin
                            if (flags.empty)
                            begin
                                cmd.st_code = ST_EMPTY;
                            end
                            else if (flags.pos_bad)
                            begin
                                cmd.st_code = ST_BADPOS;
                            end
                            else
                            begin
                                cmd.idx_op = IDX_POS;
                                state_next = S_SHIFT_DOWN;
                            end
                        end
                        default:
                        begin
                            if (flags.empty)
                            begin
                                cmd.st_code = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.cnt_op = CNT_CLR;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                // Move entries up one slot from the tail down to the gap.
                if (flags.idx_above_at)
                begin
                    cmd.wr_op  = WR_UP;
                    cmd.idx_op = IDX_DEC;
                end
                else
                begin
                    cmd.wr_op  = WR_VAL;
                    cmd.cnt_op = CNT_INC;
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_DOWN:
            begin
                // Close the gap by pulling each following entry down one slot.
                if (flags.idx_next_held)
                begin
                    cmd.wr_op  = WR_DOWN;
                    cmd.idx_op = IDX_INC;
                end
                else
                begin
                    cmd.cnt_op  = CNT_DEC;
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_OK;
                    state_next  = S_FINISH;
                end
            end
            S_SEARCH:
            begin
                if (flags.idx_end)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NOTFOUND;
                    state_next  = S_FINISH;
                end
                else if (flags.match)
                begin
                    state_next = S_SHIFT_DOWN;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bounded_array_list_engine_unit.sv
// Top level of the bounded array list engine: controller plus datapath.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+------------------------------------
//  req     | in        | req_valid/stall   | req_type, position, item_value
//  rsp     | out       | rsp_valid/stall   | status, count
//
// Refused requests, a delete at the tail and a clear are accepted and then load the
// result register. An insert moves entries up one slot from the tail down to the gap and
// then writes the new value. A delete at the head or at a position pulls each following
// entry down one slot. A delete by value compares held entries from the head; on a match it
// pulls the following entries down. One entry is moved or compared per cycle.
// Reset clears the count and the control state; the entries themselves are not cleared,
// since nothing beyond the count is ever read. A result waits in its output register
// while the next request beat is accepted; only the final hand-off waits on rsp_stall.
`default_nettype none

module bounded_array_list_engine_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bale_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bale_pkg::rsp_t      rsp
);
    import bale_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    // The controller decodes each request beat and walks the shift or search.
    bale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    // The datapath holds the entries, the count and the result register.
    bale_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .flags (flags),
        .rsp   (rsp)
    );

    // The reported count can never exceed the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count <= 5'(CAPACITY)))
    else $error("count beyond capacity");

    // A full status is only ever reported on a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> (rsp.count == 5'(CAPACITY)))
    else $error("full status with room left");

    // An empty status is only ever reported on an empty list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.count == 5'd0))
    else $error("empty status with entries held");

    // Once a request beat is taken, the engine is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while busy");

endmodule

`default_nettype wire

FILE: dv/bounded_array_list_engine_unit_tb.sv
// Self-checking testbench for the bounded array list engine: directed and random list traffic.
module bounded_array_list_engine_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bale_pkg::*;

    // The random part runs in phases. Even phases lean toward inserts so that
    // the list climbs to full. Odd phases lean toward deletes so that it drains
    // back to empty. Every sixth phase runs with no idling on either side.
    localparam int RANDOM_ITEMS = 900;
    localparam int PHASE_LEN    = 50;
    // The slowest request walks every entry once. The drain at the end waits
    // several times as long as that request takes.
    localparam int DRAIN_CYCLES = 4 * (CAPACITY + 3);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit calm = 1'b0;
    int unsigned failures = 0;

    // This is the predicted image of the list. Only entries below held_count
    // are ever read, so the contents above the count are never relied on.
    logic signed [31:0] list_shadow [CAPACITY];
    int unsigned        held_count = 0;

    // Results still owed by the block, oldest first.
    rsp_t pending_results [$];

    bounded_array_list_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // This is a hard stop in case the block hangs or never answers.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Make room at index at by moving the following entries up by one, then
    // write v there. The caller makes sure the list is not full.
    function automatic void open_slot(int unsigned at, logic signed [31:0] v);
        for (int unsigned k = held_count; k > at; k--)
            list_shadow[k] = list_shadow[k - 1];
        list_shadow[at] = v;
        held_count++;
    endfunction

    // Remove the entry at index at by moving the following entries down by one.
    function automatic void close_slot(int unsigned at);
        for (int unsigned k = at; k + 1 < held_count; k++)
            list_shadow[k] = list_shadow[k + 1];
        held_count--;
    endfunction

    // Apply one request to the shadow list and return the status and count
    // that the block should report for it. The full check comes before the
    // position check on inserts. Every delete and the clear report empty on an
    // empty list.
    function automatic rsp_t apply_request(op_t op, logic [3:0] pos,
                                           logic signed [31:0] val);
        rsp_t    res;
        status_t st;
        st = ST_OK;
        case (op)
            OP_INS_HEAD:
                if (held_count == CAPACITY) st = ST_FULL;
                else open_slot(0, val);
            OP_INS_TAIL:
                if (held_count == CAPACITY) st = ST_FULL;
                else open_slot(held_count, val);
            OP_INS_POS:
                if (held_count == CAPACITY) st = ST_FULL;
                else if (pos >= held_count) st = ST_BADPOS;
                else open_slot(pos, val);
            OP_DEL_TAIL:
                if (held_count == 0) st = ST_EMPTY;
                else held_count--;
            OP_DEL_HEAD:
                if (held_count == 0) st = ST_EMPTY;
                else close_slot(0);
            OP_DEL_VAL:
                if (held_count == 0) st = ST_EMPTY;
                else
                begin
                    // Only the held entries are searched, and only the first
                    // match is removed.
                    st = ST_NOTFOUND;
                    for (int unsigned k = 0; k < held_count; k++)
                    begin
                        if (list_shadow[k] == val)
                        begin
                            close_slot(k);
                            st = ST_OK;
                            break;
                        end
                    end
                end
            OP_DEL_POS:
                if (held_count == 0) st = ST_EMPTY;
                else if (pos >= held_count) st = ST_BADPOS;
                else close_slot(pos);
            default:
                if (held_count == 0) st = ST_EMPTY;
                else held_count = 0;
        endcase
        res.status = st;
        res.count  = 5'(held_count);
        return res;
    endfunction

    // Send one request beat. First the task may idle for a random number of
    // cycles. Then it holds the beat until the block takes it. The valid
    // stays high across back-to-back beats, so it is never dropped and raised
    // in the same time step. The expected result is queued at acceptance,
    // which keeps the prediction in the order in which the block sees the beats.
    task automatic send_request(input op_t op, input logic [3:0] pos,
                                input logic signed [31:0] val);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{req_type: op, position: pos, item_value: val};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        pending_results.push_back(apply_request(op, pos, val));
    endtask

    // On an empty list, every delete and the clear must report empty. An
    // insert at a position must report a bad position, since no position is
    // valid yet.
    task automatic test_empty_list();
        send_request(OP_CLEAR,    4'd0,  32'sd0);
        send_request(OP_DEL_TAIL, 4'd0,  32'sd0);
        send_request(OP_DEL_HEAD, 4'd0,  32'sd0);
        send_request(OP_DEL_VAL,  4'd0,  32'sd0);
        send_request(OP_DEL_POS,  4'd0,  32'sd0);
        send_request(OP_DEL_POS,  4'd15, 32'sd0);
        send_request(OP_INS_POS,  4'd0,  32'sd5);
    endtask

    // Grow the list to capacity with the extreme values and some duplicates.
    // Then every kind of insert must be refused as full. This includes an
    // insert at the last position, which would otherwise be valid.
    task automatic test_full_list();
        send_request(OP_INS_HEAD, 4'd0, 32'h7FFF_FFFF);
        send_request(OP_INS_TAIL, 4'd0, 32'h8000_0000);
        send_request(OP_INS_POS,  4'd1, -32'sd1);
        send_request(OP_INS_POS,  4'd3, 32'sd9);
        for (int i = 3; i < CAPACITY; i++)
        begin
            if (i % 2 != 0)
                send_request(OP_INS_TAIL, 4'd0, 32'(i % 5));
            else
                send_request(OP_INS_HEAD, 4'd0, 32'(i % 5));
        end
        send_request(OP_INS_HEAD, 4'd0,  32'sd1);
        send_request(OP_INS_TAIL, 4'd0,  32'sd1);
        send_request(OP_INS_POS,  4'd0,  32'sd1);
        send_request(OP_INS_POS,  4'd15, 32'sd1);
    endtask

    // Starting from the full list, this test walks the deletes. It covers the
    // last position, a position one past the end, a value that is missing, a
    // value that is held more than once, the head and tail deletes, and a
    // clear followed by a clear of the now empty list.
    task automatic test_deletes();
        send_request(OP_DEL_POS,  4'd15, 32'sd0);
        send_request(OP_DEL_POS,  4'd15, 32'sd0);
        send_request(OP_DEL_VAL,  4'd0,  32'h1234_5678);
        send_request(OP_DEL_VAL,  4'd0,  32'h8000_0000);
        send_request(OP_DEL_VAL,  4'd0,  32'sd2);
        send_request(OP_DEL_HEAD, 4'd0,  32'sd0);
        send_request(OP_DEL_TAIL, 4'd0,  32'sd0);
        send_request(OP_INS_POS,  4'd0,  32'sd77);
        send_request(OP_CLEAR,    4'd0,  32'sd0);
        send_request(OP_CLEAR,    4'd0,  32'sd0);
    endtask

    // Random traffic. Positions mostly fall inside the held range so that
    // shifts of every length happen. Values come either from the full 32-bit
    // range or from a small pool, and the pool produces duplicates. A delete
    // by value usually names a held entry, so that matches are found at every
    // depth of the search.
    task automatic test_random_traffic();
        op_t                op;
        logic [3:0]         pos;
        logic signed [31:0] val;
        int unsigned        grow_pct;
        int unsigned        pick;
        grow_pct = 75;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                grow_pct = ((n / PHASE_LEN) % 2 == 0) ? 75 : 30;
                calm     = ((n / PHASE_LEN) % 6 == 5);
            end
            pick = $urandom_range(0, 99);
            if (pick < grow_pct)
                op = op_t'($urandom_range(0, 2));
            else if (pick < 97)
                op = op_t'($urandom_range(3, 6));
            else
                op = OP_CLEAR;
            if (held_count > 0 && $urandom_range(0, 3) != 0)
                pos = 4'($urandom_range(0, held_count - 1));
            else
                pos = 4'($urandom_range(0, 15));
            if (op == OP_DEL_VAL && held_count > 0 && $urandom_range(0, 2) != 0)
                val = list_shadow[$urandom_range(0, held_count - 1)];
            else if ($urandom_range(0, 1) != 0)
                val = $urandom;
            else
                val = 32'($urandom_range(0, 7)) - 32'd4;
            send_request(op, pos, val);
        end
        calm = 1'b0;
    endtask

    // The result side. Each result beat is checked against the oldest
    // expectation. After each accepted beat, the receiver draws a new random
    // stall length, so that stalls land on every phase of the block's work.
    initial
    begin
        int unsigned stall_left;
        rsp_t        want;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat: status %0d count %0d",
                           rsp.status, rsp.count);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, rsp.status);
                        failures++;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d",
                               want.count, rsp.count);
                        failures++;
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, 6);
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Main sequence: reset, the directed tests, the random traffic, and then
    // a drain. The drain lasts until every expected result has come back,
    // plus a margin that catches any stray extra beat.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_full_list();
        test_deletes();
        test_random_traffic();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
